### src/delimited_frame_coordinate_receiver_top_assert.svh
// Assertion macros used by the RTL top module.
`ifndef DELIMITED_FRAME_COORDINATE_RECEIVER_TOP_ASSERT_SVH
`define DELIMITED_FRAME_COORDINATE_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication.
`define DFCR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DFCR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/dfcr_pkg.sv
`default_nettype none
package dfcr_pkg;

    typedef enum logic [2:0] {
        ST_INIT = 3'd0,
        ST_OK   = 3'd1,
        ST_DROP = 3'd2,
        ST_LOST = 3'd3,
        ST_NONE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_LASER  = 2'd1,
        KIND_RECT   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STAT,
        S_CHK_RD,
        S_CHK_AC,
        S_WD_HI,
        S_WD_LO,
        S_WD_OUT
    } t_state;

    localparam logic [0:0] CFG_START = 1'b0;
    localparam logic [0:0] CFG_END   = 1'b1;

    localparam logic [7:0] START_RESET = 8'h12;
    localparam logic [7:0] END_RESET   = 8'h5B;

    function automatic t_status f_track(input t_status st, input logic any,
                                        input logic seen);
        t_status res;
        if (st == ST_DROP) begin
            res = ST_DROP;
        end else if (any) begin
            res = ST_OK;
        end else if (seen) begin
            res = ST_LOST;
        end else begin
            res = ST_NONE;
        end
        return res;
    endfunction

    function automatic logic f_seen(input t_status st, input logic any, input logic seen);
        return seen | ((st != ST_DROP) & any);
    endfunction

endpackage
`default_nettype wire

### src/delimited_frame_coordinate_receiver_top.sv
// Ordinary byte: S_STAT registers its status report once the output is free, and no
// new byte is taken before that. Frame end byte: the frame buffer is read back through
// its single read port, a read and an accumulate state per checked byte, then a high
// read, low read and output state per word, and the status report last.
// Reset (synchronous, active low) clears control state; no buffer sweep, the fill
// count latched at frame end marks which buffer bytes hold received data.
`default_nettype none
`include "delimited_frame_coordinate_receiver_top_assert.svh"
module delimited_frame_coordinate_receiver_top #(
    parameter int BUF_BYTES    = 32,
    parameter int LASER_OFFSET = 1,
    parameter int LASER_BYTES  = 8,
    parameter int RECT_OFFSET  = 9,
    parameter int RECT_BYTES   = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_item_kind,
    output logic [3:0]       o_word_index,
    output logic [15:0]      o_word_value,
    output logic [2:0]       o_laser_status,
    output logic [2:0]       o_rect_status,
    output logic             o_last_of_run,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int LASER_WORDS = (LASER_BYTES + 1) / 2;
    localparam int RECT_WORDS  = (RECT_BYTES + 1) / 2;
    localparam int LASER_CHK   = LASER_BYTES / 4;
    localparam int RECT_CHK    = RECT_BYTES / 2;
    localparam int NCHK        = 2 * (LASER_CHK + RECT_CHK);
    localparam int NWORDS      = LASER_WORDS + RECT_WORDS;
    localparam int LPOS        = LASER_OFFSET + 2 * LASER_WORDS;
    localparam int RPOS        = RECT_OFFSET + 2 * RECT_WORDS;
    localparam int MAXPOS      = (LPOS > RPOS) ? LPOS : RPOS;
    localparam int PW          = $clog2(MAXPOS + 1);
    localparam int AW          = $clog2(BUF_BYTES);
    localparam int FW          = $clog2(BUF_BYTES + 1);
    localparam int XW          = (PW > FW) ? PW : FW;
    localparam int MAXCNT      = (NCHK > NWORDS) ? NCHK : NWORDS;
    localparam int CW          = $clog2(MAXCNT + 1);

    dfcr_pkg::t_state  r_state, n_state;
    logic [7:0]        r_start, r_end;
    logic              r_in_frame, n_in_frame;
    logic [FW-1:0]     r_fill, n_fill;
    logic [FW-1:0]     r_nbytes, n_nbytes;
    dfcr_pkg::t_status r_laser_st, n_laser_st;
    dfcr_pkg::t_status r_rect_st, n_rect_st;
    logic              r_l_seen, n_l_seen;
    logic              r_r_seen, n_r_seen;
    logic              r_l_any, n_l_any;
    logic              r_r_any, n_r_any;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_ok, n_ok;
    logic [7:0]        r_hi, n_hi;

    logic              r_out_valid, n_out_valid;
    dfcr_pkg::t_kind   r_out_kind, n_out_kind;
    logic [3:0]        r_out_idx, n_out_idx;
    logic [15:0]       r_out_val, n_out_val;
    dfcr_pkg::t_status r_out_lst, n_out_lst;
    dfcr_pkg::t_status r_out_rst, n_out_rst;
    logic              r_out_last, n_out_last;

    logic              w_in_acc, w_out_free;
    logic              w_is_start, w_is_end, w_stray, w_fend, w_ovf, w_drop;
    logic [FW-1:0]     w_fill_inc;
    dfcr_pkg::t_status w_lst_mid, w_rst_mid;
    logic [PW-1:0]     w_chk_pos, w_hi_pos, w_lo_pos, w_rd_pos;
    logic              w_rd_inr, w_ram_re, w_ram_we;
    logic [7:0]        w_rdata, w_rdbyte;
    logic              w_cnt_lchk, w_cnt_lwd, w_chk_last, w_wd_last;
    logic              w_l_fin, w_r_fin;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_is_start = (i_rx_byte == r_start);
    assign w_is_end   = (i_rx_byte == r_end);
    assign w_stray    = !w_is_start && !r_in_frame;
    assign w_fend     = !w_stray && !w_is_start && w_is_end;
    assign w_fill_inc = r_fill + FW'(1);
    assign w_ovf      = !w_stray && !w_fend && (w_fill_inc >= FW'(BUF_BYTES));
    assign w_drop     = (w_stray || w_ovf) && (r_laser_st != dfcr_pkg::ST_NONE);
    assign w_lst_mid  = w_drop ? dfcr_pkg::ST_DROP : r_laser_st;
    assign w_rst_mid  = w_drop ? dfcr_pkg::ST_DROP : r_rect_st;

    assign w_cnt_lchk = (r_cnt < CW'(2 * LASER_CHK));
    assign w_cnt_lwd  = (r_cnt < CW'(LASER_WORDS));
    assign w_chk_last = (r_cnt == CW'(NCHK - 1));
    assign w_wd_last  = (r_cnt == CW'(NWORDS - 1));

    assign w_chk_pos = w_cnt_lchk ? (PW'(LASER_OFFSET) + PW'(r_cnt))
                                  : (PW'(RECT_OFFSET) + PW'(r_cnt - CW'(2 * LASER_CHK)));
    assign w_hi_pos  = w_cnt_lwd ? (PW'(LASER_OFFSET) + (PW'(r_cnt) << 1))
                                 : (PW'(RECT_OFFSET) + (PW'(r_cnt - CW'(LASER_WORDS)) << 1));
    assign w_lo_pos  = w_hi_pos + PW'(1);
    assign w_rd_inr  = (XW'(w_rd_pos) < XW'(r_nbytes));
    assign w_rdbyte  = r_ok ? w_rdata : 8'h00;

    assign w_l_fin = r_l_any | (w_cnt_lchk && (w_rdbyte != 8'h00));
    assign w_r_fin = r_r_any | (!w_cnt_lchk && (w_rdbyte != 8'h00));

    dfcr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(r_fill)),
        .i_wdata (i_rx_byte),
        .i_re    (w_ram_re),
        .i_raddr (AW'(w_rd_pos)),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dfcr_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_fend ? dfcr_pkg::S_CHK_RD : dfcr_pkg::S_STAT;
                end
            end
            dfcr_pkg::S_STAT: begin
                if (w_out_free) begin
                    n_state = dfcr_pkg::S_IDLE;
                end
            end
            dfcr_pkg::S_CHK_RD: n_state = dfcr_pkg::S_CHK_AC;
            dfcr_pkg::S_CHK_AC: begin
                n_state = w_chk_last ? dfcr_pkg::S_WD_HI : dfcr_pkg::S_CHK_RD;
            end
            dfcr_pkg::S_WD_HI: n_state = dfcr_pkg::S_WD_LO;
            dfcr_pkg::S_WD_LO: n_state = dfcr_pkg::S_WD_OUT;
            dfcr_pkg::S_WD_OUT: begin
                if (w_out_free) begin
                    n_state = w_wd_last ? dfcr_pkg::S_STAT : dfcr_pkg::S_WD_HI;
                end
            end
            default: n_state = dfcr_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        w_ram_we   = 1'b0;
        w_ram_re   = 1'b0;
        w_rd_pos   = w_hi_pos;
        case (r_state)
            dfcr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                w_ram_we   = i_in_valid && !w_stray;
            end
            dfcr_pkg::S_CHK_RD: begin
                w_rd_pos = w_chk_pos;
                w_ram_re = w_rd_inr;
            end
            dfcr_pkg::S_CHK_AC: w_rd_pos = w_chk_pos;
            dfcr_pkg::S_WD_HI: w_ram_re = w_rd_inr;
            dfcr_pkg::S_WD_LO: begin
                w_rd_pos = w_lo_pos;
                w_ram_re = w_rd_inr;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_in_frame  = r_in_frame;
        n_fill      = r_fill;
        n_nbytes    = r_nbytes;
        n_laser_st  = r_laser_st;
        n_rect_st   = r_rect_st;
        n_l_seen    = r_l_seen;
        n_r_seen    = r_r_seen;
        n_l_any     = r_l_any;
        n_r_any     = r_r_any;
        n_cnt       = r_cnt;
        n_ok        = r_ok;
        n_hi        = r_hi;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_idx   = r_out_idx;
        n_out_val   = r_out_val;
        n_out_lst   = r_out_lst;
        n_out_rst   = r_out_rst;
        n_out_last  = r_out_last;
        case (r_state)
            dfcr_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (!w_stray) begin
                        n_fill = w_fill_inc;
                        if (w_is_start) begin
                            n_in_frame = 1'b1;
                        end
                    end
                    if (w_fend) begin
                        n_in_frame = 1'b0;
                        n_fill     = '0;
                        n_nbytes   = w_fill_inc;
                        n_l_any    = 1'b0;
                        n_r_any    = 1'b0;
                        n_cnt      = '0;
                    end else begin
                        if (w_ovf) begin
                            n_in_frame = 1'b0;
                            n_fill     = '0;
                        end
                        n_laser_st = dfcr_pkg::f_track(w_lst_mid, r_l_any, r_l_seen);
                        n_l_seen   = dfcr_pkg::f_seen(w_lst_mid, r_l_any, r_l_seen);
                        n_rect_st  = dfcr_pkg::f_track(w_rst_mid, r_r_any, r_r_seen);
                        n_r_seen   = dfcr_pkg::f_seen(w_rst_mid, r_r_any, r_r_seen);
                    end
                end
            end
            dfcr_pkg::S_STAT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = dfcr_pkg::KIND_STATUS;
                    n_out_idx   = 4'd0;
                    n_out_val   = 16'h0000;
                    n_out_lst   = r_laser_st;
                    n_out_rst   = r_rect_st;
                    n_out_last  = 1'b1;
                end
            end
            dfcr_pkg::S_CHK_RD: n_ok = w_rd_inr;
            dfcr_pkg::S_CHK_AC: begin
                n_l_any = w_l_fin;
                n_r_any = w_r_fin;
                if (w_chk_last) begin
                    // frame end sets both trackers to ok before the check
                    n_laser_st = dfcr_pkg::f_track(dfcr_pkg::ST_OK, w_l_fin, r_l_seen);
                    n_l_seen   = dfcr_pkg::f_seen(dfcr_pkg::ST_OK, w_l_fin, r_l_seen);
                    n_rect_st  = dfcr_pkg::f_track(dfcr_pkg::ST_OK, w_r_fin, r_r_seen);
                    n_r_seen   = dfcr_pkg::f_seen(dfcr_pkg::ST_OK, w_r_fin, r_r_seen);
                    n_cnt      = '0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            dfcr_pkg::S_WD_HI: n_ok = w_rd_inr;
            dfcr_pkg::S_WD_LO: begin
                n_hi = w_rdbyte;
                n_ok = w_rd_inr;
            end
            dfcr_pkg::S_WD_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = w_cnt_lwd ? dfcr_pkg::KIND_LASER : dfcr_pkg::KIND_RECT;
                    n_out_idx   = w_cnt_lwd ? 4'(r_cnt) : 4'(r_cnt - CW'(LASER_WORDS));
                    n_out_val   = {r_hi, w_rdbyte};
                    n_out_lst   = r_laser_st;
                    n_out_rst   = r_rect_st;
                    n_out_last  = 1'b0;
                    n_cnt       = w_wd_last ? '0 : r_cnt + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dfcr_pkg::S_IDLE;
            r_start     <= dfcr_pkg::START_RESET;
            r_end       <= dfcr_pkg::END_RESET;
            r_in_frame  <= 1'b0;
            r_fill      <= '0;
            r_nbytes    <= '0;
            r_laser_st  <= dfcr_pkg::ST_INIT;
            r_rect_st   <= dfcr_pkg::ST_INIT;
            r_l_seen    <= 1'b0;
            r_r_seen    <= 1'b0;
            r_l_any     <= 1'b0;
            r_r_any     <= 1'b0;
            r_cnt       <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_frame  <= n_in_frame;
            r_fill      <= n_fill;
            r_nbytes    <= n_nbytes;
            r_laser_st  <= n_laser_st;
            r_rect_st   <= n_rect_st;
            r_l_seen    <= n_l_seen;
            r_r_seen    <= n_r_seen;
            r_l_any     <= n_l_any;
            r_r_any     <= n_r_any;
            r_cnt       <= n_cnt;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    dfcr_pkg::CFG_START: r_start <= i_cfg_data;
                    dfcr_pkg::CFG_END:   r_end   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi       <= n_hi;
        r_out_kind <= n_out_kind;
        r_out_idx  <= n_out_idx;
        r_out_val  <= n_out_val;
        r_out_lst  <= n_out_lst;
        r_out_rst  <= n_out_rst;
        r_out_last <= n_out_last;
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_item_kind    = r_out_kind;
    assign o_word_index   = r_out_idx;
    assign o_word_value   = r_out_val;
    assign o_laser_status = r_out_lst;
    assign o_rect_status  = r_out_rst;
    assign o_last_of_run  = r_out_last;

    `DFCR_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill < FW'(BUF_BYTES),
                     "fill count reached buffer size")
    `DFCR_ASSERT_IMP(a_read_in_range, i_clk, i_rst_n, w_ram_re,
                     XW'(w_rd_pos) < XW'(r_nbytes), "buffer read past received bytes")
    `DFCR_ASSERT_IMP(a_last_on_status, i_clk, i_rst_n, r_out_valid,
                     r_out_last == (r_out_kind == dfcr_pkg::KIND_STATUS),
                     "last flag not on status report")
    `DFCR_ASSERT_NXT(a_fend_clears, i_clk, i_rst_n, w_in_acc && w_fend,
                     (r_fill == '0) && !r_in_frame && (r_state == dfcr_pkg::S_CHK_RD),
                     "frame end did not reset fill state")

endmodule
`default_nettype wire

### src/dfcr_ram.sv
`default_nettype none
module dfcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### dv/tb_top.sv
import dfcr_pkg::*;

typedef struct packed {
    t_kind       kind;
    logic [3:0]  idx;
    logic [15:0] value;
    t_status     laser;
    t_status     rect;
    logic        last;
} coord_item_t;

class frame_result_board #(
    int BUF_BYTES    = 32,
    int LASER_OFFSET = 1,
    int LASER_BYTES  = 8,
    int RECT_OFFSET  = 9,
    int RECT_BYTES   = 8
);
    localparam int LASER_WORDS = (LASER_BYTES + 1) / 2;
    localparam int RECT_WORDS  = (RECT_BYTES + 1) / 2;
    localparam int LASER_CHECK = LASER_BYTES / 4;
    localparam int RECT_CHECK  = RECT_BYTES / 2;

    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [7:0]  frame_buf[BUF_BYTES];
    bit          in_frame;
    int          fill;
    logic [15:0] laser_w[LASER_WORDS];
    logic [15:0] rect_w[RECT_WORDS];
    t_status     laser_st;
    t_status     rect_st;
    bit          laser_seen;
    bit          rect_seen;
    coord_item_t due_words[$];
    int          errors;

    function new();
        start_code = START_RESET;
        end_code   = END_RESET;
        foreach (frame_buf[i]) frame_buf[i] = '0;
        foreach (laser_w[i]) laser_w[i] = '0;
        foreach (rect_w[i]) rect_w[i] = '0;
        in_frame   = 0;
        fill       = 0;
        laser_st   = ST_INIT;
        rect_st    = ST_INIT;
        laser_seen = 0;
        rect_seen  = 0;
        errors     = 0;
    endfunction

    function logic [7:0] buf_at(int pos);
        return (pos < BUF_BYTES) ? frame_buf[pos] : 8'h00;
    endfunction

    function void flag_drop();
        if (laser_st != ST_NONE) begin
            laser_st = ST_DROP;
            rect_st  = ST_DROP;
        end
    endfunction

    function void update_status(bit any, ref t_status st, ref bit seen);
        if (st != ST_DROP) begin
            if (any) begin
                st   = ST_OK;
                seen = 1;
            end else begin
                st = seen ? ST_LOST : ST_NONE;
            end
        end
    endfunction

    function void absorb_byte(logic [7:0] b);
        bit closed;
        bit any;
        int p;
        coord_item_t r;
        closed = 0;
        if (b != start_code && !in_frame) begin
            flag_drop();
        end else begin
            if (fill < BUF_BYTES) frame_buf[fill] = b;
            fill++;
            if (b == start_code) begin
                in_frame = 1;
            end else if (b == end_code) begin
                in_frame = 0;
                fill     = 0;
                closed   = 1;
                for (int k = 0; k < LASER_WORDS; k++) begin
                    p = LASER_OFFSET + 2 * k;
                    laser_w[k] = {buf_at(p), buf_at(p + 1)};
                end
                for (int k = 0; k < RECT_WORDS; k++) begin
                    p = RECT_OFFSET + 2 * k;
                    rect_w[k] = {buf_at(p), buf_at(p + 1)};
                end
                foreach (frame_buf[i]) frame_buf[i] = '0;
                laser_st = ST_OK;
                rect_st  = ST_OK;
            end
            if (fill >= BUF_BYTES) begin
                flag_drop();
                in_frame = 0;
                fill     = 0;
                foreach (frame_buf[i]) frame_buf[i] = '0;
            end
        end

        any = 0;
        for (int k = 0; k < LASER_CHECK; k++) any |= (laser_w[k] != 0);
        update_status(any, laser_st, laser_seen);
        any = 0;
        for (int k = 0; k < RECT_CHECK; k++) any |= (rect_w[k] != 0);
        update_status(any, rect_st, rect_seen);

        r.laser = laser_st;
        r.rect  = rect_st;
        r.last  = 0;
        if (closed) begin
            r.kind = KIND_LASER;
            for (int k = 0; k < LASER_WORDS; k++) begin
                r.idx   = 4'(k);
                r.value = laser_w[k];
                due_words.push_back(r);
            end
            r.kind = KIND_RECT;
            for (int k = 0; k < RECT_WORDS; k++) begin
                r.idx   = 4'(k);
                r.value = rect_w[k];
                due_words.push_back(r);
            end
        end
        r.kind  = KIND_STATUS;
        r.idx   = '0;
        r.value = '0;
        r.last  = 1;
        due_words.push_back(r);
    endfunction

    function void match_result(logic [1:0] kind, logic [3:0] idx, logic [15:0] value,
                               logic [2:0] lst, logic [2:0] rst, logic last);
        coord_item_t e;
        if (due_words.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result kind=%0d idx=%0d value=%h ls=%0d rs=%0d last=%0d",
                         kind, idx, value, lst, rst, last);
            return;
        end
        e = due_words.pop_front();
        if (kind !== e.kind || idx !== e.idx || value !== e.value ||
            lst !== e.laser || rst !== e.rect || last !== e.last) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: exp kind=%0d idx=%0d value=%h ls=%0d rs=%0d last=%0d | got kind=%0d idx=%0d value=%h ls=%0d rs=%0d last=%0d",
                         e.kind, e.idx, e.value, e.laser, e.rect, e.last,
                         kind, idx, value, lst, rst, last);
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_BYTES    = 32;
    localparam int LASER_OFFSET = 1;
    localparam int LASER_BYTES  = 8;
    localparam int RECT_OFFSET  = 9;
    localparam int RECT_BYTES   = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 80;
    localparam int HOLD_CYCLES  = 400;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [0:0]  i_cfg_index = CFG_START;
    logic [7:0]  i_cfg_data  = 8'h00;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_item_kind;
    logic [3:0]  o_word_index;
    logic [15:0] o_word_value;
    logic [2:0]  o_laser_status;
    logic [2:0]  o_rect_status;
    logic        o_last_of_run;
    logic        o_cfg_ready;

    frame_result_board #(BUF_BYTES, LASER_OFFSET, LASER_BYTES, RECT_OFFSET, RECT_BYTES) sb;

    int unsigned rx_cycle   = 0;
    int          hold_left  = 0;
    bit          hold_req   = 0;
    int          burst_left = 0;

    delimited_frame_coordinate_receiver_top #(
        .BUF_BYTES   (BUF_BYTES),
        .LASER_OFFSET(LASER_OFFSET),
        .LASER_BYTES (LASER_BYTES),
        .RECT_OFFSET (RECT_OFFSET),
        .RECT_BYTES  (RECT_BYTES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_item_kind   (o_item_kind),
        .o_word_index  (o_word_index),
        .o_word_value  (o_word_value),
        .o_laser_status(o_laser_status),
        .o_rect_status (o_rect_status),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // result side: check transfers, then pick next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.match_result(o_item_kind, o_word_index, o_word_value,
                            o_laser_status, o_rect_status, o_last_of_run);
        rx_cycle++;
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0: i_out_ready <= 1'b1;
                2'd1: i_out_ready <= 1'($urandom_range(0, 1));
                2'd2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (rx_cycle[1:0] != 2'd0);
            endcase
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.absorb_byte(b);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.due_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_delims(input logic [7:0] s, input logic [7:0] e);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_START;
        i_cfg_data  <= s;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.start_code = s;
        i_cfg_index <= CFG_END;
        i_cfg_data  <= e;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.end_code = e;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] payload_byte(input bit sparse);
        logic [7:0] b;
        b = (sparse && $urandom_range(0, 4) != 0) ? 8'h00 : 8'($urandom);
        while (b == sb.start_code || b == sb.end_code) b = 8'($urandom);
        return b;
    endfunction

    task automatic run_random(input int budget, input bit force_overflow);
        int sent;
        int pick;
        int len;
        logic [7:0] b;
        bit sparse;
        sent = 0;
        while (sent < budget) begin
            pick = (sent == 0 && force_overflow) ? 99 : $urandom_range(0, 99);
            if (pick < 70) begin
                sparse = ($urandom_range(0, 3) == 0);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 30)
                                                  : $urandom_range(0, 16);
                push_byte(sb.start_code);
                repeat (len) push_byte(payload_byte(sparse));
                push_byte(sb.end_code);
                sent += len + 2;
            end else if (pick < 82) begin
                len = $urandom_range(1, 3);
                repeat (len) begin
                    b = 8'($urandom);
                    if (b == sb.start_code) b = ~b;
                    push_byte(b);
                end
                sent += len;
            end else if (pick < 94) begin
                // restart inside a frame; the first part may close the frame early
                push_byte(sb.start_code);
                len = $urandom_range(0, 5);
                repeat (len) push_byte(8'($urandom));
                push_byte(sb.start_code);
                repeat ($urandom_range(0, 8)) begin
                    push_byte(payload_byte(0));
                    sent++;
                end
                push_byte(sb.end_code);
                sent += len + 3;
            end else begin
                // fill the buffer to the last slot
                push_byte(sb.start_code);
                for (int i = 0; i < BUF_BYTES - 1; i++) begin
                    b = payload_byte($urandom_range(0, 1));
                    if (i == BUF_BYTES - 2 && (force_overflow || $urandom_range(0, 1) == 1))
                        b = sb.start_code;
                    push_byte(b);
                end
                sent += BUF_BYTES;
            end
        end
    endtask

    logic [7:0] dir_bytes[25] = '{
        8'h00, 8'hFF,
        8'h12, 8'h5B,
        8'h37,
        8'h12, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h80, 8'h01, 8'hFF, 8'h5B,
        8'h12, 8'hAA, 8'h12, 8'hBB, 8'h5B,
        8'h12, 8'h00, 8'h00, 8'h5B,
        8'h5B
    };

    initial begin
        logic [7:0] s;
        logic [7:0] e;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray bytes, empty frame, stray while never found, half laser check,
        // restart inside frame, all-zero frame, stray end byte
        foreach (dir_bytes[i]) push_byte(dir_bytes[i]);
        wait_drained();

        hold_req = 1;
        run_random(65, 1);
        wait_drained();

        write_delims(8'h00, 8'hFF);
        run_random(65, 0);
        wait_drained();

        write_delims(8'hFF, 8'h00);
        run_random(65, 1);
        wait_drained();

        // start and end share a value: frames never close
        write_delims(8'hA5, 8'hA5);
        run_random(65, 0);
        wait_drained();

        s = 8'($urandom);
        e = 8'($urandom);
        if (e == s) e = ~s;
        write_delims(s, e);
        run_random(65, 0);
        wait_drained();

        if (sb.due_words.size() != 0) begin
            sb.errors++;
            $display("ERROR: %0d expected results never arrived", sb.due_words.size());
        end
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### delimited_frame_coordinate_receiver_top.f
+incdir+src
src/dfcr_pkg.sv
src/dfcr_ram.sv
src/delimited_frame_coordinate_receiver_top.sv
dv/tb_top.sv
